// File: src/ppg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the plasma pixel generator.
// No dependencies; every design file under src imports this package.
package ppg_pkg;

    localparam int XW = 10;
    localparam int YW = 10;
    localparam int TW = 9;
    localparam int CW = 8;
    localparam int DW = 20;   // squared distance from the screen center
    localparam int MW = 32;   // scaled squared distance
    localparam int NCELLS = 8;

    localparam logic [XW-1:0] CENTER_X = 10'd512;
    localparam logic [YW-1:0] CENTER_Y = 10'd384;
    // 65025 / 409600 reduced by 25: q <= sqrt(65025*D)/640  <=>  16384*q*q <= 2601*D
    localparam logic [11:0] RADIAL_SCALE = 12'd2601;
    localparam int SQ_SHIFT = 14;

    typedef struct packed {
        logic [MW-1:0] m;
        logic [CW-1:0] q;
        logic [CW-1:0] addr_h;
        logic [CW-1:0] addr_v;
        logic [CW-1:0] addr_d;
        logic [CW-1:0] phase_r;
    } cell_t;

    localparam logic [7:0] SINE_ROM [256] = '{
        8'd127, 8'd130, 8'd133, 8'd136, 8'd139, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd184, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd221, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd253, 8'd253,
        8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247, 8'd246,
        8'd245, 8'd244, 8'd242, 8'd241, 8'd239, 8'd238, 8'd236, 8'd235,
        8'd233, 8'd231, 8'd229, 8'd228, 8'd226, 8'd224, 8'd221, 8'd219,
        8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
        8'd198, 8'd195, 8'd193, 8'd190, 8'd187, 8'd184, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd164, 8'd161, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd139, 8'd136, 8'd133, 8'd130,
        8'd127, 8'd124, 8'd121, 8'd118, 8'd115, 8'd111, 8'd108, 8'd105,
        8'd102, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
        8'd78,  8'd75,  8'd72,  8'd70,  8'd67,  8'd64,  8'd61,  8'd59,
        8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd41,  8'd39,
        8'd37,  8'd35,  8'd33,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,
        8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
        8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
        8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
        8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
        8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
        8'd21,  8'd23,  8'd25,  8'd26,  8'd28,  8'd30,  8'd33,  8'd35,
        8'd37,  8'd39,  8'd41,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
        8'd56,  8'd59,  8'd61,  8'd64,  8'd67,  8'd70,  8'd72,  8'd75,
        8'd78,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
        8'd102, 8'd105, 8'd108, 8'd111, 8'd115, 8'd118, 8'd121, 8'd124
    };

endpackage

// File: src/plasma_pixel_generator_top.sv
`timescale 1ns / 1ps
// Plasma pixel generator: one palette index per pixel, one item per cycle while the output accepts.
// Stages: 3 front stages (offsets, squares, scale multiply), 8 root cells
// (one radial index bit each) and the lookup/output register.
// Each stage holds independently, so bubbles close up while the output waits.
// Reset (rst_n, asynchronous, active low) empties the pipeline; the sine table is constant.
module plasma_pixel_generator_top
    import ppg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [9:0] pixel_x, [19:10] pixel_y, [28:20] frame_phase
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] color_index
);

    logic  chain_valid [NCELLS+1];
    logic  chain_ready [NCELLS+1];
    cell_t chain_cell  [NCELLS+1];

    ppg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pixel_x     (s_axis_tdata[XW-1:0]),
        .pixel_y     (s_axis_tdata[XW+YW-1:XW]),
        .frame_phase (s_axis_tdata[XW+YW+TW-1:XW+YW]),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_cell    (chain_cell[0])
    );

    // most significant bit first
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        ppg_root_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .trial     (CW'(1) << (NCELLS - 1 - i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    ppg_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (chain_valid[NCELLS]),
        .in_ready    (chain_ready[NCELLS]),
        .in_cell     (chain_cell[NCELLS]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .color_index (m_axis_tdata)
    );

    // An empty output register frees every stage behind it.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // A front item blocked by the first cell is held, not dropped.
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] && !chain_ready[0] |=> chain_valid[0] && $stable(chain_cell[0]))
        else $error("front item lost while stalled");

    // The settled radial index never overshoots the scaled distance.
    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[NCELLS] |->
            ({16'd0, chain_cell[NCELLS].q} * {16'd0, chain_cell[NCELLS].q})
                * 32'd16384 <= chain_cell[NCELLS].m)
        else $error("radial index too large");

endmodule

// File: src/ppg_front.sv
`timescale 1ns / 1ps
// Front end: phase terms, wave addresses and the scaled squared distance.
// Three stages; depends on ppg_pkg.
module ppg_front
    import ppg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [XW-1:0] pixel_x,
    input  logic [YW-1:0] pixel_y,
    input  logic [TW-1:0] frame_phase,
    output logic          out_valid,
    input  logic          out_ready,
    output cell_t         out_cell
);

    // stage A: addresses and absolute offsets
    logic          a_valid_reg;
    logic [XW-1:0] a_ax_reg;
    logic [YW-1:0] a_ay_reg;
    cell_t         a_cell_reg;
    // stage B: squared distance
    logic          b_valid_reg;
    logic [DW-1:0] b_d_reg;
    cell_t         b_cell_reg;
    // stage C: scaled squared distance
    logic          c_valid_reg;
    cell_t         c_cell_reg;

    logic a_ready, b_ready, c_ready;
    logic [CW-1:0] p1, p2, p3, p4, hx, hy;
    logic [XW-1:0] ax_next;
    logic [YW-1:0] ay_next;
    cell_t         a_cell_next;
    logic [2*XW-1:0] sqx;
    logic [2*YW-1:0] sqy;
    logic [DW-1:0]   d_next;
    logic [MW-1:0]   m_next;
    cell_t           c_cell_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        p1 = frame_phase[CW-1:0];
        p2 = frame_phase[CW-1:0] + frame_phase[TW-1:1];
        p3 = {frame_phase[CW-2:0], 1'b0};
        p4 = frame_phase[CW-1:0] + {frame_phase[CW-2:0], 1'b0};
        hx = pixel_x[CW:1];
        hy = pixel_y[CW:1];
        ax_next = (pixel_x >= CENTER_X) ? (pixel_x - CENTER_X) : (CENTER_X - pixel_x);
        ay_next = (pixel_y >= CENTER_Y) ? (pixel_y - CENTER_Y) : (CENTER_Y - pixel_y);
        a_cell_next         = '0;
        a_cell_next.addr_h  = hx + p2;
        a_cell_next.addr_v  = hy + p1;
        a_cell_next.addr_d  = hx + hy + p3;
        a_cell_next.phase_r = p4;
    end

    always_comb
    begin
        sqx    = {{XW{1'b0}}, a_ax_reg} * {{XW{1'b0}}, a_ax_reg};
        sqy    = {{YW{1'b0}}, a_ay_reg} * {{YW{1'b0}}, a_ay_reg};
        d_next = sqx + sqy;
        m_next = MW'(b_d_reg) * MW'(RADIAL_SCALE);
        c_cell_next   = b_cell_reg;
        c_cell_next.m = m_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_ax_reg   <= ax_next;
            a_ay_reg   <= ay_next;
            a_cell_reg <= a_cell_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_d_reg    <= d_next;
            b_cell_reg <= a_cell_reg;
        end
        if (c_ready && b_valid_reg)
            c_cell_reg <= c_cell_next;
    end

    assign out_valid = c_valid_reg;
    assign out_cell  = c_cell_reg;

endmodule

// File: src/ppg_root_cell.sv
`timescale 1ns / 1ps
// One cell of the radial root chain: settles one bit of the radial index.
// Depends on ppg_pkg.
module ppg_root_cell
    import ppg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [CW-1:0] trial,     // one-hot bit this cell decides
    input  logic          in_valid,
    output logic          in_ready,
    input  cell_t         in_cell,
    output logic          out_valid,
    input  logic          out_ready,
    output cell_t         out_cell
);

    logic          valid_reg;
    cell_t         cell_reg;
    cell_t         cell_next;
    logic [CW-1:0] cand;
    logic [2*CW-1:0] sq;
    logic          fits;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        cand = in_cell.q | trial;
        sq   = {{CW{1'b0}}, cand} * {{CW{1'b0}}, cand};
        fits = {{(MW-2*CW-SQ_SHIFT){1'b0}}, sq, {SQ_SHIFT{1'b0}}} <= in_cell.m;
        cell_next   = in_cell;
        // keep the bit only while 16384*q*q stays within the scaled distance
        cell_next.q = fits ? cand : in_cell.q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cell_reg <= cell_next;
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// File: src/ppg_mix.sv
`timescale 1ns / 1ps
// Sine lookups of the four waves, their average, and the output register.
// Depends on ppg_pkg.
module ppg_mix
    import ppg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cell_t         in_cell,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [CW-1:0] color_index
);

    logic          valid_reg;
    logic [CW-1:0] color_reg;
    logic [CW-1:0] addr_r;
    logic [CW+1:0] sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        addr_r = in_cell.q + in_cell.phase_r;
        sum = {2'b00, SINE_ROM[in_cell.addr_h]} + {2'b00, SINE_ROM[in_cell.addr_v]}
            + {2'b00, SINE_ROM[in_cell.addr_d]} + {2'b00, SINE_ROM[addr_r]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            color_reg <= sum[CW+1:2];
    end

    assign out_valid   = valid_reg;
    assign color_index = color_reg;

endmodule

// File: tb/tb_plasma_pixel_generator_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for plasma_pixel_generator_top: streams pixels in, predicts the
// palette index of each one and compares it with the output stream in order.
// Depends on src/ppg_pkg.sv and src/plasma_pixel_generator_top.sv.
module tb_plasma_pixel_generator_top;

    localparam int CENTER_COL = 512;
    localparam int CENTER_ROW = 384;
    localparam int PIPE_DEPTH = 12;

    // Expected palette indexes, oldest first, and the per-pixel predictor.
    class color_ledger;
        logic [7:0] wave [256];
        logic [7:0] expected_colors [$];
        int failures;
        int pixels_in;
        int colors_out;

        function new();
            wave = '{
                127, 130, 133, 136, 139, 143, 146, 149, 152, 155, 158, 161, 164, 167, 170, 173,
                176, 179, 182, 184, 187, 190, 193, 195, 198, 200, 203, 205, 208, 210, 213, 215,
                217, 219, 221, 224, 226, 228, 229, 231, 233, 235, 236, 238, 239, 241, 242, 244,
                245, 246, 247, 248, 249, 250, 251, 251, 252, 253, 253, 254, 254, 254, 254, 254,
                255, 254, 254, 254, 254, 254, 253, 253, 252, 251, 251, 250, 249, 248, 247, 246,
                245, 244, 242, 241, 239, 238, 236, 235, 233, 231, 229, 228, 226, 224, 221, 219,
                217, 215, 213, 210, 208, 205, 203, 200, 198, 195, 193, 190, 187, 184, 182, 179,
                176, 173, 170, 167, 164, 161, 158, 155, 152, 149, 146, 143, 139, 136, 133, 130,
                127, 124, 121, 118, 115, 111, 108, 105, 102,  99,  96,  93,  90,  87,  84,  81,
                 78,  75,  72,  70,  67,  64,  61,  59,  56,  54,  51,  49,  46,  44,  41,  39,
                 37,  35,  33,  30,  28,  26,  25,  23,  21,  19,  18,  16,  15,  13,  12,  10,
                  9,   8,   7,   6,   5,   4,   3,   3,   2,   1,   1,   0,   0,   0,   0,   0,
                  0,   0,   0,   0,   0,   0,   1,   1,   2,   3,   3,   4,   5,   6,   7,   8,
                  9,  10,  12,  13,  15,  16,  18,  19,  21,  23,  25,  26,  28,  30,  33,  35,
                 37,  39,  41,  44,  46,  49,  51,  54,  56,  59,  61,  64,  67,  70,  72,  75,
                 78,  81,  84,  87,  90,  93,  96,  99, 102, 105, 108, 111, 115, 118, 121, 124
            };
            failures = 0;
            pixels_in = 0;
            colors_out = 0;
        endfunction

        // floor(255 * dist / 640), saturated at 255
        function logic [7:0] radial_step(logic [9:0] x, logic [9:0] y);
            longint unsigned dx;
            longint unsigned dy;
            longint unsigned scaled;
            longint unsigned root;
            longint unsigned cand;
            longint unsigned q;
            dx = (x >= CENTER_COL) ? longint'(x) - CENTER_COL : CENTER_COL - longint'(x);
            dy = (y >= CENTER_ROW) ? longint'(y) - CENTER_ROW : CENTER_ROW - longint'(y);
            scaled = (dx * dx + dy * dy) * 65025;
            root = 0;
            // the root stays below 2^18 for every 10-bit coordinate pair
            for (int b = 17; b >= 0; b--)
            begin
                cand = root | (longint'(1) << b);
                if (cand * cand <= scaled)
                    root = cand;
            end
            q = root / 640;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function logic [7:0] plasma_index(logic [9:0] x, logic [9:0] y, logic [8:0] t);
            logic [7:0] ph_v;
            logic [7:0] ph_h;
            logic [7:0] ph_d;
            logic [7:0] ph_r;
            logic [8:0] hx;
            logic [8:0] hy;
            logic [7:0] addr_h;
            logic [7:0] addr_v;
            logic [7:0] addr_d;
            logic [7:0] addr_r;
            int sum;
            ph_v = t[7:0];
            ph_h = 8'(t + (t >> 1));
            ph_d = {t[6:0], 1'b0};
            ph_r = 8'(t * 3);
            hx = x[9:1];
            hy = y[9:1];
            addr_h = 8'(hx + ph_h);
            addr_v = 8'(hy + ph_v);
            addr_d = 8'(hx + hy[7:0] + ph_d);
            addr_r = 8'(radial_step(x, y) + ph_r);
            sum = int'(wave[addr_h]) + int'(wave[addr_v]) + int'(wave[addr_d])
                + int'(wave[addr_r]);
            return 8'(sum >> 2);
        endfunction

        function void note_pixel(logic [9:0] x, logic [9:0] y, logic [8:0] t);
            expected_colors.push_back(plasma_index(x, y, t));
            pixels_in++;
        endfunction

        function void check_color(logic [7:0] actual);
            logic [7:0] exp_color;
            colors_out++;
            if (expected_colors.size() == 0)
            begin
                $error("color_index: item with no pixel pending, expected none, actual %0d",
                       actual);
                failures++;
            end
            else
            begin
                exp_color = expected_colors.pop_front();
                if (exp_color !== actual)
                begin
                    $error("color_index mismatch: expected %0d, actual %0d", exp_color, actual);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    color_ledger ledger = new();

    plasma_pixel_generator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            ledger.note_pixel(s_axis_tdata[9:0], s_axis_tdata[19:10], s_axis_tdata[28:20]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_color(m_axis_tdata);
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_pixel(logic [9:0] x, logic [9:0] y, logic [8:0] t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, t, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Mostly raster runs along one row, the rest scattered pixels over the full field.
    task automatic send_random_pixels(int count);
        int sent;
        int run_len;
        logic [9:0] x0;
        logic [9:0] row;
        logic [8:0] phase;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 7)
            begin
                x0 = 10'($urandom_range(1023));
                row = ($urandom_range(7) == 0) ? 10'($urandom_range(1023, 768))
                                               : 10'($urandom_range(767));
                phase = 9'($urandom_range(511));
                run_len = $urandom_range(24, 1);
                for (int i = 0; i < run_len && sent < count; i++)
                begin
                    send_pixel(10'(x0 + i), row, phase);
                    sent++;
                end
            end
            else
            begin
                send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                           9'($urandom_range(511)));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corners, screen center, rows past the screen, phase wrap points
        sender_idle_pct = 29;
        receiver_idle_pct = 77;
        send_pixel(10'd0,    10'd0,    9'd0);
        send_pixel(10'd1023, 10'd767,  9'd511);
        send_pixel(10'd512,  10'd384,  9'd0);
        send_pixel(10'd512,  10'd384,  9'd511);
        send_pixel(10'd511,  10'd383,  9'd1);
        send_pixel(10'd513,  10'd385,  9'd509);
        send_pixel(10'd1023, 10'd0,    9'd255);
        send_pixel(10'd0,    10'd767,  9'd256);
        send_pixel(10'd0,    10'd1023, 9'd85);
        send_pixel(10'd1023, 10'd1023, 9'd170);
        send_pixel(10'd512,  10'd1023, 9'd341);
        send_pixel(10'd512,  10'd768,  9'd2);
        send_pixel(10'd0,    10'd384,  9'd128);
        send_pixel(10'd1023, 10'd384,  9'd384);
        send_pixel(10'd512,  10'd0,    9'd3);
        send_pixel(10'd2,    10'd2,    9'd510);
        send_pixel(10'd682,  10'd341,  9'd427);
        send_pixel(10'd341,  10'd682,  9'd84);

        send_random_pixels(178);
        sender_idle_pct = 77;
        receiver_idle_pct = 29;
        send_random_pixels(177);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        send_random_pixels(177);
        s_axis_tvalid <= 1'b0;

        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("Checked %0d palette indexes for %0d pixels: corners, center, off-screen rows,",
                 ledger.colors_out, ledger.pixels_in);
        $display("raster runs and scattered pixels under three stall patterns.");
        if (ledger.failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
